@@ sv/frq_pkg.sv @@
// ----------------------------------------------------------------------------
// frq_pkg
// Shared types and constants of the rendezvous queue: request codes, response
// kinds, the command passed from front to back, and the fixed field widths.
// ----------------------------------------------------------------------------
package frq_pkg;

  localparam int REQ_W       = 2;
  localparam int KIND_W      = 3;
  localparam int WORD_W      = 32;
  localparam int ID_W        = 4;
  localparam int COUNT_W     = 5;
  localparam int VISIT_W     = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;
  localparam int CMDQ_DEPTH  = 2;

  localparam logic [REQ_W-1:0] REQ_ENQ = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ = 2'd1;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_TRY
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVER   = 3'd0,
    KIND_STORED    = 3'd1,
    KIND_PARKED    = 3'd2,
    KIND_EMPTY     = 3'd3,
    KIND_DATA_FULL = 3'd4,
    KIND_WAIT_FULL = 3'd5
  } kind_e;

  typedef enum logic {
    ST_DECIDE,
    ST_READ
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] data;
    logic [ID_W-1:0]   rid;
  } cmd_t;

endpackage

@@ sv/frq_front.sv @@
// ----------------------------------------------------------------------------
// frq_front
// Accepts request items, decodes the request code and buffers the commands
// in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module frq_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [frq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // data_in, requester_id
  input  logic [frq_pkg::REQ_W-1:0]           s_axis_tuser,  // req_type
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output frq_pkg::cmd_t                       cmd_o
);

  localparam int PTR_W = $clog2(frq_pkg::CMDQ_DEPTH);
  localparam int CNT_W = $clog2(frq_pkg::CMDQ_DEPTH + 1);

  frq_pkg::cmd_t          q_mem_q [frq_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  frq_pkg::cmd_t          in_cmd;
  logic                   push, pop;

  always_comb begin
    in_cmd.data = s_axis_tdata[frq_pkg::WORD_W-1:0];
    in_cmd.rid  = s_axis_tdata[frq_pkg::WORD_W +: frq_pkg::ID_W];
    case (s_axis_tuser)
      frq_pkg::REQ_ENQ: in_cmd.op = frq_pkg::OP_ENQ;
      frq_pkg::REQ_DEQ: in_cmd.op = frq_pkg::OP_DEQ;
      default:          in_cmd.op = frq_pkg::OP_TRY;
    endcase
  end

  assign s_axis_tready = (cnt_q != CNT_W'(frq_pkg::CMDQ_DEPTH));
  assign cmd_valid_o   = (cnt_q != '0);
  assign cmd_o         = q_mem_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(frq_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(frq_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

@@ sv/frq_back.sv @@
// ----------------------------------------------------------------------------
// frq_back
// Executes commands against the word FIFO and the waiter FIFO, keeps the
// counts and drives the registered result item.
// ----------------------------------------------------------------------------
module frq_back #(
  parameter int DATA_DEPTH = 16,
  parameter int DATA_WIDTH = 32,
  parameter int REQUESTERS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  output logic                                cmd_ready_o,
  input  frq_pkg::cmd_t                       cmd_i,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [frq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [frq_pkg::KIND_W-1:0]          m_axis_tuser
);

  localparam int SW   = (DATA_WIDTH < frq_pkg::WORD_W) ? DATA_WIDTH : frq_pkg::WORD_W;
  localparam int WA_W = $clog2(DATA_DEPTH);
  localparam int WC_W = $clog2(DATA_DEPTH + 1);
  localparam int QA_W = $clog2(REQUESTERS);
  localparam int QC_W = $clog2(REQUESTERS + 1);
  localparam int PAD_W = frq_pkg::OUT_TDATA_W - 2 * frq_pkg::WORD_W - frq_pkg::ID_W
                         - 2 * frq_pkg::COUNT_W;

  logic [SW-1:0]               word_mem [DATA_DEPTH];
  logic [frq_pkg::ID_W-1:0]    waiter_mem [REQUESTERS];
  logic [SW-1:0]               word_rdata_q;
  logic [frq_pkg::ID_W-1:0]    waiter_rdata_q;

  frq_pkg::state_e             state_q, state_d;
  logic [WA_W-1:0]             word_head_q, word_head_d, word_tail_q, word_tail_d;
  logic [WC_W-1:0]             word_cnt_q, word_cnt_d;
  logic [QA_W-1:0]             waiter_head_q, waiter_head_d, waiter_tail_q, waiter_tail_d;
  logic [QC_W-1:0]             waiter_cnt_q, waiter_cnt_d;
  logic [frq_pkg::VISIT_W-1:0] visit_q, visit_d;

  frq_pkg::kind_e              kind_q, kind_d;
  logic [frq_pkg::WORD_W-1:0]  pdata_q, pdata_d;
  logic [frq_pkg::ID_W-1:0]    pdest_q, pdest_d;
  logic                        use_word_q, use_word_d;
  logic                        use_waiter_q, use_waiter_d;

  logic                        out_valid_q;
  logic [frq_pkg::OUT_TDATA_W-1:0] out_data_q;
  frq_pkg::kind_e              out_kind_q;

  logic                        fire, out_free, load_out;
  logic                        word_we, word_re, waiter_we, waiter_re;
  logic [frq_pkg::WORD_W-1:0]  res_data;
  logic [frq_pkg::ID_W-1:0]    res_dest;

  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      frq_pkg::ST_DECIDE: if (cmd_valid_i) state_d = frq_pkg::ST_READ;
      frq_pkg::ST_READ:   if (out_free) state_d = frq_pkg::ST_DECIDE;
      default:            state_d = frq_pkg::ST_DECIDE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      frq_pkg::ST_DECIDE: cmd_ready_o = 1'b1;
      frq_pkg::ST_READ:   load_out    = out_free;
      default:            cmd_ready_o = 1'b0;
    endcase
  end

  assign fire = cmd_valid_i && cmd_ready_o;

  always_comb begin
    word_head_d   = word_head_q;
    word_tail_d   = word_tail_q;
    word_cnt_d    = word_cnt_q;
    waiter_head_d = waiter_head_q;
    waiter_tail_d = waiter_tail_q;
    waiter_cnt_d  = waiter_cnt_q;
    visit_d       = visit_q;
    kind_d        = kind_q;
    pdata_d       = pdata_q;
    pdest_d       = pdest_q;
    use_word_d    = use_word_q;
    use_waiter_d  = use_waiter_q;
    word_we       = 1'b0;
    word_re       = 1'b0;
    waiter_we     = 1'b0;
    waiter_re     = 1'b0;
    if (fire) begin
      pdata_d      = '0;
      pdest_d      = '0;
      use_word_d   = 1'b0;
      use_waiter_d = 1'b0;
      case (cmd_i.op)
        frq_pkg::OP_ENQ: begin
          if (waiter_cnt_q != '0) begin
            kind_d       = frq_pkg::KIND_DELIVER;
            pdata_d      = frq_pkg::WORD_W'(cmd_i.data[SW-1:0]);
            use_waiter_d = 1'b1;
            waiter_re    = 1'b1;
          end else if (word_cnt_q == WC_W'(DATA_DEPTH)) begin
            kind_d = frq_pkg::KIND_DATA_FULL;
          end else begin
            kind_d  = frq_pkg::KIND_STORED;
            word_we = 1'b1;
          end
        end
        frq_pkg::OP_DEQ: begin
          if (word_cnt_q != '0) begin
            kind_d = frq_pkg::KIND_DELIVER;
            word_re = 1'b1;
          end else if (waiter_cnt_q == QC_W'(REQUESTERS)) begin
            kind_d = frq_pkg::KIND_WAIT_FULL;
          end else begin
            kind_d    = frq_pkg::KIND_PARKED;
            waiter_we = 1'b1;
          end
        end
        default: begin
          if (word_cnt_q != '0) begin
            kind_d  = frq_pkg::KIND_DELIVER;
            word_re = 1'b1;
          end else begin
            kind_d = frq_pkg::KIND_EMPTY;
          end
        end
      endcase
      if (word_re) begin
        use_word_d  = 1'b1;
        pdest_d     = cmd_i.rid;
        word_head_d = (word_head_q == WA_W'(DATA_DEPTH - 1)) ? '0 : word_head_q + 1'b1;
        word_cnt_d  = word_cnt_q - 1'b1;
        visit_d     = visit_q + 1'b1;
      end
      if (word_we) begin
        word_tail_d = (word_tail_q == WA_W'(DATA_DEPTH - 1)) ? '0 : word_tail_q + 1'b1;
        word_cnt_d  = word_cnt_q + 1'b1;
      end
      if (waiter_re) begin
        waiter_head_d = (waiter_head_q == QA_W'(REQUESTERS - 1)) ? '0 : waiter_head_q + 1'b1;
        waiter_cnt_d  = waiter_cnt_q - 1'b1;
      end
      if (waiter_we) begin
        waiter_tail_d = (waiter_tail_q == QA_W'(REQUESTERS - 1)) ? '0 : waiter_tail_q + 1'b1;
        waiter_cnt_d  = waiter_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[word_tail_q] <= cmd_i.data[SW-1:0];
    end
    if (word_re) begin
      word_rdata_q <= word_mem[word_head_q];
    end
    if (waiter_we) begin
      waiter_mem[waiter_tail_q] <= cmd_i.rid;
    end
    if (waiter_re) begin
      waiter_rdata_q <= waiter_mem[waiter_head_q];
    end
  end

  assign res_data = use_word_q ? frq_pkg::WORD_W'(word_rdata_q) : pdata_q;
  assign res_dest = use_waiter_q ? waiter_rdata_q : pdest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= frq_pkg::ST_DECIDE;
      word_head_q   <= '0;
      word_tail_q   <= '0;
      word_cnt_q    <= '0;
      waiter_head_q <= '0;
      waiter_tail_q <= '0;
      waiter_cnt_q  <= '0;
      visit_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      word_head_q   <= word_head_d;
      word_tail_q   <= word_tail_d;
      word_cnt_q    <= word_cnt_d;
      waiter_head_q <= waiter_head_d;
      waiter_tail_q <= waiter_tail_d;
      waiter_cnt_q  <= waiter_cnt_d;
      visit_q       <= visit_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    pdata_q      <= pdata_d;
    pdest_q      <= pdest_d;
    use_word_q   <= use_word_d;
    use_waiter_q <= use_waiter_d;
    if (load_out) begin
      out_kind_q <= kind_q;
      out_data_q <= {PAD_W'(1'b0), visit_q,
                     frq_pkg::COUNT_W'(waiter_cnt_q), frq_pkg::COUNT_W'(word_cnt_q),
                     res_dest, res_data};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

`ifndef NO_ASSERTIONS
  a_word_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_cnt_q <= WC_W'(DATA_DEPTH))
    else $error("word count above depth");

  a_waiter_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiter_cnt_q <= QC_W'(REQUESTERS))
    else $error("waiter count above depth");

  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((word_cnt_q != '0) && (waiter_cnt_q != '0)))
    else $error("words stored while consumers parked");

  a_read_follows_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (state_q == frq_pkg::ST_READ) && !cmd_ready_o)
    else $error("command not followed by result stage");
`endif

endmodule

@@ sv/fifo_rendezvous_queue.sv @@
// ----------------------------------------------------------------------------
// fifo_rendezvous_queue
// Mailbox queue that pairs enqueued words with parked consumers in FIFO order.
//
//   channel   dir  tuser          tdata (low to high)
//   s_axis    in   req_type       data_in, requester_id
//   m_axis    out  resp_kind      data_out, dest_id, stored_count,
//                                 waiting_count, visited_count
//
// The back end handles an item in a decide state, which decides and reads the head of a FIFO
// memory, then a result state, which loads the result register; it takes no new command before that.
// The front buffers up to two items, so input takes up to two more items while a result stalls.
// Reset clears pointers, counts and valid flags; no clearing pass of memories.
// A stalled result register holds the back end in its result stage.
// ----------------------------------------------------------------------------
module fifo_rendezvous_queue #(
  parameter int DATA_DEPTH = 16,
  parameter int DATA_WIDTH = 32,
  parameter int REQUESTERS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [frq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // data_in, requester_id
  input  logic [frq_pkg::REQ_W-1:0]           s_axis_tuser,  // req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // data_out, dest_id, stored_count, waiting_count, visited_count
  output logic [frq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [frq_pkg::KIND_W-1:0]          m_axis_tuser   // resp_kind
);

  logic          cmd_valid;
  logic          cmd_ready;
  frq_pkg::cmd_t cmd;

  frq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  frq_back #(
    .DATA_DEPTH (DATA_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .REQUESTERS (REQUESTERS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
